// ===== src/pcp_pkg.sv =====
`timescale 1ns / 1ps

package pcp_pkg;

   // Coordinate and register formats.
   typedef logic signed [15:0] coord_type;
   typedef logic signed [31:0] prod_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CAM0 = 3'd0,
      REG_CAM1 = 3'd1,
      REG_CAM2 = 3'd2,
      REG_AUX0 = 3'd3,
      REG_AUX1 = 3'd4,
      REG_AUX2 = 3'd5,
      REG_INTR = 3'd6,
      REG_SIZE = 3'd7
   } csr_index_type;

   localparam logic [63:0] ROW0_RESET = 64'h4000_0000_0000_0000;
   localparam logic [63:0] ROW1_RESET = 64'h0000_4000_0000_0000;
   localparam logic [63:0] ROW2_RESET = 64'h0000_0000_4000_0000;

   // Open crop box limits per sensor, Q7.8 metres.
   localparam coord_type S0_X_LO = 16'sd0;
   localparam coord_type S0_X_HI = 16'sd12800;
   localparam coord_type S0_Y_LO = -16'sd2560;
   localparam coord_type S0_Y_HI = 16'sd2560;
   localparam coord_type S0_Z_LO = -16'sd1280;
   localparam coord_type S0_Z_HI = 16'sd768;
   localparam coord_type S1_X_LO = 16'sd0;
   localparam coord_type S1_X_HI = 16'sd2560;
   localparam coord_type S1_Y_LO = -16'sd12800;
   localparam coord_type S1_Y_HI = 16'sd5120;
   localparam coord_type S1_Z_LO = -16'sd1280;
   localparam coord_type S1_Z_HI = 16'sd1280;

   // Camera-frame box.
   localparam coord_type CAM_XY_LIM = 16'sd1280;
   localparam coord_type ZC_MIN     = 16'sd51;
   localparam coord_type ZC_MAX     = 16'sd10240;

   // Divider layout: magnitude bits, quotient bits resolved per stage.
   localparam int NUM_W       = 32;
   localparam int REM_W       = 16;
   localparam int DIV_W       = 15;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = NUM_W / DIV_STEPS;

   // One divider lane: the dividend shifts out on top while quotient bits
   // shift in at the bottom.
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [REM_W-1:0] rem;
   } div_lane_type;

   // Saturate a transform row result to 16 bits.
   function automatic coord_type sat16(input logic signed [20:0] v);
      coord_type r;
      if (v > 21'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Saturate a pixel coordinate to 0..65535.
   function automatic logic [15:0] sat_u16(input logic signed [33:0] v);
      logic [15:0] r;
      if (v < 34'sd0) begin
         r = 16'h0000;
      end else if (v > 34'sd65535) begin
         r = 16'hFFFF;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/pcp_if.sv =====
`timescale 1ns / 1ps

// Point request channel.
interface pcp_req_if;
   logic        valid;
   logic        ready;
   logic        sensor;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic [15:0] point_z;
   logic        mask_in;

   modport source (output valid, sensor, point_x, point_y, point_z, mask_in, input ready);
   modport sink   (input valid, sensor, point_x, point_y, point_z, mask_in, output ready);
endinterface

// Projection result channel.
interface pcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        keep;
   logic [15:0] pixel_u;
   logic [15:0] pixel_v;
   logic [15:0] depth;

   modport source (output valid, keep, pixel_u, pixel_v, depth, input ready);
   modport sink   (input valid, keep, pixel_u, pixel_v, depth, output ready);
endinterface

// ===== src/pcp_div_stage.sv =====
`timescale 1ns / 1ps

module pcp_div_stage
   import pcp_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  div_lane_type       lane_in,
   input  logic [DIV_W-1:0]   divisor,
   output div_lane_type       lane_out
);

   div_lane_type lane_ff;
   div_lane_type lane_in_next;

   // Restoring division, several quotient bits per stage.
   always_comb begin
      lane_in_next = lane_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
         lane_in_next.rem = {lane_in_next.rem[REM_W-2:0], lane_in_next.num[NUM_W-1]};
         lane_in_next.num = {lane_in_next.num[NUM_W-2:0], 1'b0};
         if (lane_in_next.rem >= {1'b0, divisor}) begin
            lane_in_next.rem    = lane_in_next.rem - {1'b0, divisor};
            lane_in_next.num[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_next;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== src/lidar_point_crop_and_camera_projection.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake     | Payload
// req_if    | in        | valid / ready | sensor, point_x, point_y, point_z, mask_in
// rsp_if    | out       | valid / ready | keep, pixel_u, pixel_v, depth
// csr_*     | in        | csr_we        | csr_index, csr_wdata
//
// One request per cycle is accepted while the pipeline is not stalled.
// The pipeline holds the two transform passes and the eight-stage divider.
// Reset clears the valid bits, the intrinsics and the image size, and loads the identity transforms.
// Each stage holds only while the stage after it is full and stalled.

module lidar_point_crop_and_camera_projection
   import pcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pcp_req_if.sink     req_if,
   pcp_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int NSTG   = 17;
   localparam int DIV0   = 7;
   localparam int F1_IDX = DIV0 + DIV_STAGES;
   localparam int OUT_IDX = F1_IDX + 1;

   // Configuration registers.
   logic [63:0] cam_row_ff [3];
   logic [63:0] aux_row_ff [3];
   logic [63:0] intr_ff;
   logic [23:0] size_ff;
   csr_index_type csr_sel;

   assign csr_sel = csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_row_ff[0] <= ROW0_RESET;
         cam_row_ff[1] <= ROW1_RESET;
         cam_row_ff[2] <= ROW2_RESET;
         aux_row_ff[0] <= ROW0_RESET;
         aux_row_ff[1] <= ROW1_RESET;
         aux_row_ff[2] <= ROW2_RESET;
         intr_ff       <= '0;
         size_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_sel)
            REG_CAM0: cam_row_ff[0] <= csr_wdata;
            REG_CAM1: cam_row_ff[1] <= csr_wdata;
            REG_CAM2: cam_row_ff[2] <= csr_wdata;
            REG_AUX0: aux_row_ff[0] <= csr_wdata;
            REG_AUX1: aux_row_ff[1] <= csr_wdata;
            REG_AUX2: aux_row_ff[2] <= csr_wdata;
            REG_INTR: intr_ff       <= csr_wdata;
            REG_SIZE: size_ff       <= csr_wdata[23:0];
            default:  ;
         endcase
      end
   end

   // Valid bits and per-stage advance enables.
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG:0]   en;

   assign en[NSTG] = rsp_if.ready;
   for (genvar i = 0; i < NSTG; i++) begin : g_en
      assign en[i] = !v_ff[i] || en[i+1];
   end

   assign req_if.ready = en[0];
   assign v_in[0] = req_if.valid;
   for (genvar i = 1; i < NSTG; i++) begin : g_vin
      assign v_in[i] = v_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // Stage 1: register the point and apply the sensor crop box.
   coord_type in_p [3];
   logic      crop_ok;
   coord_type s1_p_ff [3];
   logic      s1_sensor_ff;
   logic      s1_ok_ff;

   assign in_p[0] = $signed(req_if.point_x);
   assign in_p[1] = $signed(req_if.point_y);
   assign in_p[2] = $signed(req_if.point_z);

   always_comb begin
      if (req_if.sensor) begin
         crop_ok = in_p[0] > S1_X_LO && in_p[0] < S1_X_HI && in_p[1] > S1_Y_LO
                && in_p[1] < S1_Y_HI && in_p[2] > S1_Z_LO && in_p[2] < S1_Z_HI;
      end else begin
         crop_ok = in_p[0] > S0_X_LO && in_p[0] < S0_X_HI && in_p[1] > S0_Y_LO
                && in_p[1] < S0_Y_HI && in_p[2] > S0_Z_LO && in_p[2] < S0_Z_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_p_ff      <= in_p;
         s1_sensor_ff <= req_if.sensor;
         s1_ok_ff     <= req_if.mask_in && crop_ok;
      end
   end

   // Stage 2: aux transform products.
   prod_type  s2_prod_ff [3][3];
   coord_type s2_p_ff [3];
   logic      s2_sensor_ff;
   logic      s2_ok_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               s2_prod_ff[k][j] <= prod_type'($signed(aux_row_ff[k][63-16*j -: 16]))
                                 * prod_type'(s1_p_ff[j]);
            end
         end
         s2_p_ff      <= s1_p_ff;
         s2_sensor_ff <= s1_sensor_ff;
         s2_ok_ff     <= s1_ok_ff;
      end
   end

   // Stage 3: aux row sums; sensor 0 points pass unchanged.
   coord_type s3_a_in [3];
   coord_type s3_a_ff [3];
   logic      s3_ok_ff;

   always_comb begin
      logic signed [33:0] acc;
      for (int k = 0; k < 3; k++) begin
         acc = 34'(s2_prod_ff[k][0]) + 34'(s2_prod_ff[k][1]) + 34'(s2_prod_ff[k][2]);
         s3_a_in[k] = s2_sensor_ff
                    ? sat16(21'($signed(acc[33:14])) + 21'($signed(aux_row_ff[k][15:0])))
                    : s2_p_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_a_ff  <= s3_a_in;
         s3_ok_ff <= s2_ok_ff;
      end
   end

   // Stage 4: camera transform products.
   prod_type s4_prod_ff [3][3];
   logic     s4_ok_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               s4_prod_ff[k][j] <= prod_type'($signed(cam_row_ff[k][63-16*j -: 16]))
                                 * prod_type'(s3_a_ff[j]);
            end
         end
         s4_ok_ff <= s3_ok_ff;
      end
   end

   // Stage 5: camera row sums and the camera box test.
   coord_type s5_c_in [3];
   coord_type s5_c_ff [3];
   logic      s5_ok_ff;
   logic      s5_pos_ff;

   always_comb begin
      logic signed [33:0] acc;
      for (int k = 0; k < 3; k++) begin
         acc = 34'(s4_prod_ff[k][0]) + 34'(s4_prod_ff[k][1]) + 34'(s4_prod_ff[k][2]);
         s5_c_in[k] = sat16(21'($signed(acc[33:14])) + 21'($signed(cam_row_ff[k][15:0])));
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_c_ff   <= s5_c_in;
         s5_ok_ff  <= s4_ok_ff && s5_c_in[0] > -CAM_XY_LIM && s5_c_in[0] < CAM_XY_LIM
                   && s5_c_in[1] > -CAM_XY_LIM && s5_c_in[1] < CAM_XY_LIM
                   && s5_c_in[2] < ZC_MAX;
         s5_pos_ff <= s5_c_in[2] > ZC_MIN;
      end
   end

   // Stage 6: projection numerators.
   logic signed [32:0] s6_nu_ff;
   logic signed [32:0] s6_nv_ff;
   coord_type          s6_zc_ff;
   logic               s6_ok_ff;
   logic               s6_pos_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_nu_ff  <= 33'($signed({1'b0, intr_ff[63:48]})) * 33'(s5_c_ff[0]);
         s6_nv_ff  <= 33'($signed({1'b0, intr_ff[47:32]})) * 33'(s5_c_ff[1]);
         s6_zc_ff  <= s5_c_ff[2];
         s6_ok_ff  <= s5_ok_ff;
         s6_pos_ff <= s5_pos_ff;
      end
   end

   // Sideband that travels beside the divider lanes.
   typedef struct packed {
      logic             neg_u;
      logic             neg_v;
      logic [DIV_W-1:0] divisor;
      coord_type        depth;
      logic             ok;
      logic             pos;
   } side_type;

   // Stage 7: magnitudes and signs enter the divider.
   div_lane_type s7_u_ff;
   div_lane_type s7_v_ff;
   side_type     s7_side_ff;
   logic [32:0]  mag_u;
   logic [32:0]  mag_v;

   assign mag_u = s6_nu_ff[32] ? 33'(-s6_nu_ff) : s6_nu_ff;
   assign mag_v = s6_nv_ff[32] ? 33'(-s6_nv_ff) : s6_nv_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_u_ff.num        <= mag_u[NUM_W-1:0];
         s7_u_ff.rem        <= '0;
         s7_v_ff.num        <= mag_v[NUM_W-1:0];
         s7_v_ff.rem        <= '0;
         s7_side_ff.neg_u   <= s6_nu_ff[32];
         s7_side_ff.neg_v   <= s6_nv_ff[32];
         s7_side_ff.divisor <= s6_zc_ff[DIV_W-1:0];
         s7_side_ff.depth   <= s6_zc_ff;
         s7_side_ff.ok      <= s6_ok_ff;
         s7_side_ff.pos     <= s6_pos_ff;
      end
   end

   // Divider stages.
   div_lane_type lane_u [DIV_STAGES+1];
   div_lane_type lane_v [DIV_STAGES+1];
   side_type     side_ff [DIV_STAGES+1];

   assign lane_u[0] = s7_u_ff;
   assign lane_v[0] = s7_v_ff;
   assign side_ff[0] = s7_side_ff;

   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      pcp_div_stage u_div_u (
         .clock    (clock),
         .en       (en[DIV0+d]),
         .lane_in  (lane_u[d]),
         .divisor  (side_ff[d].divisor),
         .lane_out (lane_u[d+1])
      );

      pcp_div_stage u_div_v (
         .clock    (clock),
         .en       (en[DIV0+d]),
         .lane_in  (lane_v[d]),
         .divisor  (side_ff[d].divisor),
         .lane_out (lane_v[d+1])
      );

      always_ff @(posedge clock) begin
         if (en[DIV0+d]) begin
            side_ff[d+1] <= side_ff[d];
         end
      end
   end

   // Final stage 1: signed quotients plus principal point.
   logic signed [33:0] f1_u_ff;
   logic signed [33:0] f1_v_ff;
   side_type           f1_side_ff;
   logic signed [33:0] q_u;
   logic signed [33:0] q_v;

   assign q_u = side_ff[DIV_STAGES].neg_u ? -$signed({2'b0, lane_u[DIV_STAGES].num})
                                          : $signed({2'b0, lane_u[DIV_STAGES].num});
   assign q_v = side_ff[DIV_STAGES].neg_v ? -$signed({2'b0, lane_v[DIV_STAGES].num})
                                          : $signed({2'b0, lane_v[DIV_STAGES].num});

   always_ff @(posedge clock) begin
      if (en[F1_IDX]) begin
         f1_u_ff    <= q_u + $signed({18'b0, intr_ff[31:16]});
         f1_v_ff    <= q_v + $signed({18'b0, intr_ff[15:0]});
         f1_side_ff <= side_ff[DIV_STAGES];
      end
   end

   // Final stage 2: image test and saturation into the output register.
   logic signed [33:0] cols16;
   logic signed [33:0] rows16;
   logic               in_image;
   logic               out_keep_ff;
   logic [15:0]        out_u_ff;
   logic [15:0]        out_v_ff;
   coord_type          out_depth_ff;

   assign cols16   = $signed({18'b0, size_ff[23:12], 4'b0});
   assign rows16   = $signed({18'b0, size_ff[11:0], 4'b0});
   assign in_image = f1_u_ff > 34'sd0 && f1_u_ff < cols16
                  && f1_v_ff > 34'sd0 && f1_v_ff < rows16;

   always_ff @(posedge clock) begin
      if (en[OUT_IDX]) begin
         out_keep_ff  <= f1_side_ff.ok && f1_side_ff.pos && in_image;
         out_u_ff     <= f1_side_ff.pos ? sat_u16(f1_u_ff) : 16'h0000;
         out_v_ff     <= f1_side_ff.pos ? sat_u16(f1_v_ff) : 16'h0000;
         out_depth_ff <= f1_side_ff.depth;
      end
   end

   assign rsp_if.valid   = v_ff[OUT_IDX];
   assign rsp_if.keep    = out_keep_ff;
   assign rsp_if.pixel_u = out_u_ff;
   assign rsp_if.pixel_v = out_v_ff;
   assign rsp_if.depth   = out_depth_ff;

`ifndef SYNTHESIS
   // A kept point always had a positive depth above the projection floor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.keep |-> $signed(rsp_if.depth) > ZC_MIN)
      else $error("kept point with depth at or below the projection floor");

   // A kept point lies strictly inside the image, so no pixel coordinate is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.keep |-> rsp_if.pixel_u != 16'h0000 && rsp_if.pixel_v != 16'h0000)
      else $error("kept point with a zero pixel coordinate");

   // A ready result side always lets a request in.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("request stalled while the result side is ready");

   // Nothing leaves the pipeline right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");
`endif

endmodule

// ===== tb/tb_lidar_point_crop_and_camera_projection.sv =====
`timescale 1ns / 1ps

import pcp_pkg::*;

// One lidar point as offered on the request channel.
typedef struct {
   logic        sensor;
   logic [15:0] point_x;
   logic [15:0] point_y;
   logic [15:0] point_z;
   logic        mask_in;
} lidar_point_type;

// One projected point as seen on the result channel.
typedef struct {
   logic        keep;
   logic [15:0] pixel_u;
   logic [15:0] pixel_v;
   logic [15:0] depth;
} pixel_result_type;

// Keeps a shadow of the registers and the projections still owed by the block.
class projection_scoreboard;
   logic [63:0]      shadow_regs [8];
   pixel_result_type owed_pixels [$];
   int               mismatches;

   function void load_reset_values();
      shadow_regs[REG_CAM0] = ROW0_RESET;
      shadow_regs[REG_CAM1] = ROW1_RESET;
      shadow_regs[REG_CAM2] = ROW2_RESET;
      shadow_regs[REG_AUX0] = ROW0_RESET;
      shadow_regs[REG_AUX1] = ROW1_RESET;
      shadow_regs[REG_AUX2] = ROW2_RESET;
      shadow_regs[REG_INTR] = 64'd0;
      shadow_regs[REG_SIZE] = 64'd0;
      mismatches = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [63:0] data);
      // The image size register holds only 24 bits.
      if (idx == REG_SIZE) begin
         shadow_regs[idx] = {40'd0, data[23:0]};
      end else begin
         shadow_regs[idx] = data;
      end
   endfunction

   function longint sign16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function longint clamp16(longint v);
      if (v > 32767) begin
         return 32767;
      end else if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   function longint clamp_pixel(longint v);
      if (v < 0) begin
         return 0;
      end else if (v > 65535) begin
         return 65535;
      end
      return v;
   endfunction

   // One transform row: exact sum of Q1.14 products, floored once, plus translation.
   function longint transform_row(logic [63:0] row, longint a, longint b, longint c);
      longint acc;
      acc = sign16(row[63:48]) * a + sign16(row[47:32]) * b + sign16(row[31:16]) * c;
      return clamp16((acc >>> 14) + sign16(row[15:0]));
   endfunction

   function void transform_point(int base, longint p [3], output longint q [3]);
      for (int k = 0; k < 3; k++) begin
         q[k] = transform_row(shadow_regs[base + k], p[0], p[1], p[2]);
      end
   endfunction

   // Crop, move into the camera frame and project one point.
   function pixel_result_type project_point(lidar_point_type pt);
      pixel_result_type res;
      longint p [3];
      longint s1 [3];
      longint cam [3];
      longint fx, fy, cx, cy, cols16, rows16, u, v;
      bit     ok;
      p[0] = sign16(pt.point_x);
      p[1] = sign16(pt.point_y);
      p[2] = sign16(pt.point_z);
      ok = pt.mask_in;
      if (pt.sensor == 1'b0) begin
         ok = ok && p[0] > S0_X_LO && p[0] < S0_X_HI && p[1] > S0_Y_LO && p[1] < S0_Y_HI
              && p[2] > S0_Z_LO && p[2] < S0_Z_HI;
         transform_point(REG_CAM0, p, cam);
      end else begin
         ok = ok && p[0] > S1_X_LO && p[0] < S1_X_HI && p[1] > S1_Y_LO && p[1] < S1_Y_HI
              && p[2] > S1_Z_LO && p[2] < S1_Z_HI;
         transform_point(REG_AUX0, p, s1);
         transform_point(REG_CAM0, s1, cam);
      end
      ok = ok && cam[0] > -longint'(CAM_XY_LIM) && cam[0] < CAM_XY_LIM
           && cam[1] > -longint'(CAM_XY_LIM) && cam[1] < CAM_XY_LIM && cam[2] < ZC_MAX;
      res.pixel_u = 16'd0;
      res.pixel_v = 16'd0;
      // Project only in front of the near plane; otherwise the point is not kept and its pixel stays zero.
      if (cam[2] > ZC_MIN) begin
         fx = longint'(shadow_regs[REG_INTR][63:48]);
         fy = longint'(shadow_regs[REG_INTR][47:32]);
         cx = longint'(shadow_regs[REG_INTR][31:16]);
         cy = longint'(shadow_regs[REG_INTR][15:0]);
         cols16 = longint'(shadow_regs[REG_SIZE][23:12]);
         rows16 = longint'(shadow_regs[REG_SIZE][11:0]);
         cols16 = cols16 * 16;
         rows16 = rows16 * 16;
         u = (fx * cam[0]) / cam[2] + cx;
         v = (fy * cam[1]) / cam[2] + cy;
         ok = ok && u > 0 && u < cols16 && v > 0 && v < rows16;
         res.pixel_u = 16'(clamp_pixel(u));
         res.pixel_v = 16'(clamp_pixel(v));
      end else begin
         ok = 1'b0;
      end
      res.keep  = ok;
      res.depth = cam[2][15:0];
      return res;
   endfunction

   function void note_request(lidar_point_type pt);
      owed_pixels = {owed_pixels, project_point(pt)};
   endfunction

   function void check_result(pixel_result_type got);
      pixel_result_type want;
      if (owed_pixels.size() == 0) begin
         $display("%0t: unexpected result keep=%0b u=%h v=%h depth=%h", $time,
                  got.keep, got.pixel_u, got.pixel_v, got.depth);
         mismatches++;
         return;
      end
      want = owed_pixels.pop_front();
      if (got.keep !== want.keep) begin
         $display("%0t: keep expected %0b actual %0b", $time, want.keep, got.keep);
         mismatches++;
      end
      if (got.pixel_u !== want.pixel_u) begin
         $display("%0t: pixel_u expected %h actual %h", $time, want.pixel_u, got.pixel_u);
         mismatches++;
      end
      if (got.pixel_v !== want.pixel_v) begin
         $display("%0t: pixel_v expected %h actual %h", $time, want.pixel_v, got.pixel_v);
         mismatches++;
      end
      if (got.depth !== want.depth) begin
         $display("%0t: depth expected %h actual %h", $time, want.depth, got.depth);
         mismatches++;
      end
   endfunction

   function int pending();
      return owed_pixels.size();
   endfunction
endclass

module tb_lidar_point_crop_and_camera_projection;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   bit          steady_flow;
   int          hold_request;
   int          hold_left;
   int          cycle_count;

   projection_scoreboard projections;

   pcp_req_if req_ch ();
   pcp_rsp_if rsp_ch ();

   lidar_point_crop_and_camera_projection u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock.
   initial begin
      clock = 1'b0;
   end
   always begin
      #10 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Note each accepted request and check each accepted result.
   always @(posedge clock) begin
      lidar_point_type  pt;
      pixel_result_type res;
      if (!reset && req_ch.valid && req_ch.ready) begin
         pt.sensor  = req_ch.sensor;
         pt.point_x = req_ch.point_x;
         pt.point_y = req_ch.point_y;
         pt.point_z = req_ch.point_z;
         pt.mask_in = req_ch.mask_in;
         projections.note_request(pt);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         res.keep    = rsp_ch.keep;
         res.pixel_u = rsp_ch.pixel_u;
         res.pixel_v = rsp_ch.pixel_v;
         res.depth   = rsp_ch.depth;
         projections.check_result(res);
      end
   end

   // Result receiver: random stalls, steady stretches and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 37);
      end
   end

   // One register write; the write port then goes idle before the task returns.
   task automatic csr_write(csr_index_type idx, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      projections.write_reg(idx, data);
      @(posedge clock);
   endtask

   // Offer one request, with a random gap first unless the flow is steady, and hold it until accepted.
   task automatic send_point(lidar_point_type pt);
      while (!steady_flow && $urandom_range(99) < 37) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.sensor  <= pt.sensor;
      req_ch.point_x <= pt.point_x;
      req_ch.point_y <= pt.point_y;
      req_ch.point_z <= pt.point_z;
      req_ch.mask_in <= pt.mask_in;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   task automatic send_xyz(bit sensor, int x, int y, int z, bit mask);
      lidar_point_type pt;
      pt.sensor  = sensor;
      pt.point_x = 16'(x);
      pt.point_y = 16'(y);
      pt.point_z = 16'(z);
      pt.mask_in = mask;
      send_point(pt);
   endtask

   // Stop offering and wait until every owed result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (projections.pending() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_inside(int lo, int hi);
      // Mostly strictly inside, sometimes right on a limit or just inside it.
      case ($urandom_range(9))
         0: return lo;
         1: return hi;
         2: return lo + 1;
         3: return hi - 1;
         default: return $urandom_range(hi - lo - 2) + lo + 1;
      endcase
   endfunction

   // Random points: mostly inside the crop box of their sensor, some pure noise.
   task automatic send_random(int count);
      lidar_point_type pt;
      for (int n = 0; n < count; n++) begin
         pt.sensor  = 1'($urandom_range(1));
         pt.mask_in = ($urandom_range(9) != 0);
         if ($urandom_range(99) < 30) begin
            pt.point_x = 16'($urandom);
            pt.point_y = 16'($urandom);
            pt.point_z = 16'($urandom);
         end else if (pt.sensor == 1'b0) begin
            pt.point_x = 16'(pick_inside(S0_X_LO, S0_X_HI));
            pt.point_y = 16'(pick_inside(S0_Y_LO, S0_Y_HI));
            pt.point_z = 16'(pick_inside(S0_Z_LO, S0_Z_HI));
         end else begin
            pt.point_x = 16'(pick_inside(S1_X_LO, S1_X_HI));
            pt.point_y = 16'(pick_inside(S1_Y_LO, S1_Y_HI));
            pt.point_z = 16'(pick_inside(S1_Z_LO, S1_Z_HI));
         end
         send_point(pt);
      end
   endtask

   // Forward-looking camera: xc = -y, yc = -z, zc = x; sensor 1 sits 1 m ahead.
   task automatic load_front_camera();
      csr_write(REG_CAM0, 64'h0000_C000_0000_0000);
      csr_write(REG_CAM1, 64'h0000_0000_C000_0000);
      csr_write(REG_CAM2, 64'h4000_0000_0000_0000);
      csr_write(REG_AUX0, 64'h4000_0000_0000_0100);
      csr_write(REG_AUX1, 64'h0000_4000_0000_0000);
      csr_write(REG_AUX2, 64'h0000_0000_4000_0000);
      csr_write(REG_INTR, 64'h1F40_1F40_1400_0F00);
      csr_write(REG_SIZE, 64'h0000_0000_0028_01E0);
   endtask

   task automatic load_random_regs();
      for (int k = 0; k < 8; k++) begin
         csr_write(csr_index_type'(k), {$urandom, $urandom});
      end
   endtask

   // Stimulus.
   initial begin
      projections = new();
      projections.load_reset_values();
      cycle_count    = 0;
      hold_request   = 0;
      hold_left      = 0;
      steady_flow    = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_CAM0;
      csr_wdata      = 64'd0;
      req_ch.valid   = 1'b0;
      req_ch.sensor  = 1'b0;
      req_ch.point_x = 16'd0;
      req_ch.point_y = 16'd0;
      req_ch.point_z = 16'd0;
      req_ch.mask_in = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: zero image size rejects everything, near plane still applies.
      send_xyz(0, 1000, 100, 100, 1);
      send_xyz(0, 0, 0, 51, 1);
      send_xyz(1, 100, 0, 52, 1);
      wait_drained();

      // Directed points with a forward camera.
      load_front_camera();
      send_xyz(0, 2560, 0, 0, 1);
      send_xyz(0, 2560, 0, 0, 0);
      send_xyz(0, 0, 0, 0, 1);
      send_xyz(0, 12800, 0, 0, 1);
      send_xyz(0, 12799, 10, -10, 1);
      send_xyz(0, 51, 0, 0, 1);
      send_xyz(0, 52, 0, 0, 1);
      send_xyz(0, 1000, -2560, 0, 1);
      send_xyz(0, 1000, 2559, 767, 1);
      send_xyz(0, 1000, 0, -1280, 1);
      send_xyz(0, 1000, 0, -1279, 1);
      send_xyz(0, 32767, 32767, 32767, 1);
      send_xyz(0, -32768, -32768, -32768, 1);
      send_xyz(1, 1, -12799, 1279, 1);
      send_xyz(1, 2559, 5119, -1279, 1);
      send_xyz(1, 1000, 200, 100, 1);
      send_xyz(1, -256, 0, 0, 1);
      send_xyz(1, 2560, 0, 0, 1);
      send_xyz(0, 300, 1000, 0, 1);
      send_xyz(0, 300, -1000, 0, 1);
      wait_drained();

      // Random points, first with steady flow, then with stalls.
      steady_flow = 1'b1;
      send_random(80);
      steady_flow = 1'b0;
      send_random(140);

      // Receiver holds off while requests keep coming, so the pipeline backs up.
      hold_request = 300;
      send_random(60);
      wait_drained();
      send_random(60);
      wait_drained();

      // Extremes: all ones, then all zeros.
      for (int k = 0; k < 8; k++) begin
         csr_write(csr_index_type'(k), 64'hFFFF_FFFF_FFFF_FFFF);
      end
      send_random(60);
      wait_drained();
      for (int k = 0; k < 8; k++) begin
         csr_write(csr_index_type'(k), 64'd0);
      end
      send_random(40);
      wait_drained();

      // Large positive and negative terms so products and sums saturate.
      csr_write(REG_CAM0, 64'h7FFF_7FFF_7FFF_7FFF);
      csr_write(REG_CAM1, 64'h8000_8000_8000_8000);
      csr_write(REG_CAM2, 64'h7FFF_0000_0000_7FFF);
      csr_write(REG_AUX0, 64'h8000_7FFF_8000_8000);
      csr_write(REG_INTR, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_SIZE, 64'h0000_0000_00FF_FFFF);
      send_random(40);
      wait_drained();

      // Random register settings.
      for (int phase = 0; phase < 3; phase++) begin
         load_random_regs();
         send_random(40);
         wait_drained();
      end

      // Back to a sensible camera with random intrinsics and image size.
      load_front_camera();
      csr_write(REG_INTR, {16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                           16'($urandom_range(16'h3FFF)), 16'($urandom_range(16'h3FFF))});
      csr_write(REG_SIZE, {$urandom, $urandom});
      send_random(180);
      wait_drained();

      if (projections.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/pcp_pkg.sv
src/pcp_if.sv
src/pcp_div_stage.sv
src/lidar_point_crop_and_camera_projection.sv
tb/tb_lidar_point_crop_and_camera_projection.sv
